FILE: rtl/core/ahgd_pkg.sv
// Shared types, constants and tables for the accelerometer hit detector.
// No dependencies.
`default_nettype none
package ahgd_pkg;
   localparam int CordicStepsDefault = 16;
   localparam int CordicStepsMax     = 24;
   localparam int AngW               = 32;
   localparam int CorW               = 48;

   localparam logic [2:0] ZONE_SNARE   = 3'd0;
   localparam logic [2:0] ZONE_HIHAT   = 3'd1;
   localparam logic [2:0] ZONE_TOM     = 3'd2;
   localparam logic [2:0] ZONE_CRASH   = 3'd3;
   localparam logic [2:0] ZONE_NEUTRAL = 3'd4;

   localparam logic [2:0] CSR_X_BIAS   = 3'd0;
   localparam logic [2:0] CSR_Y_BIAS   = 3'd1;
   localparam logic [2:0] CSR_Z_BIAS   = 3'd2;
   localparam logic [2:0] CSR_HAND     = 3'd3;
   localparam logic [2:0] CSR_GAP      = 3'd4;
   localparam logic [2:0] CSR_WINDOW   = 3'd5;

   typedef struct packed {
      logic signed [17:0] az;
      logic signed [16:0] ay;
      logic signed [16:0] ax;
      logic [31:0]        time_us;
   } item_type;

   typedef struct packed {
      logic [31:0] min_gap;
      logic [31:0] arm_win;
      logic        hand;
   } ctl_type;

   function automatic logic signed [AngW-1:0] atan_lut(input logic [4:0] i);
      logic signed [AngW-1:0] r;
      begin
         unique case (i)
            5'd0: r = 2949120;  5'd1: r = 1740967;  5'd2: r = 919879;
            5'd3: r = 466945;   5'd4: r = 234379;   5'd5: r = 117304;
            5'd6: r = 58666;    5'd7: r = 29335;    5'd8: r = 14668;
            5'd9: r = 7334;     5'd10: r = 3667;    5'd11: r = 1833;
            5'd12: r = 917;     5'd13: r = 458;     5'd14: r = 229;
            5'd15: r = 115;     5'd16: r = 57;      5'd17: r = 29;
            5'd18: r = 14;      5'd19: r = 7;       5'd20: r = 4;
            5'd21: r = 2;       5'd22: r = 1;
            default: r = 0;
         endcase
         return r;
      end
   endfunction
endpackage
`default_nettype wire

FILE: rtl/core/ahgd_front.sv
// Front end: bias subtraction and input capture into a two-entry queue.
// Depends on ahgd_pkg.
`default_nettype none
module ahgd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [79:0]        req_tdata,
   input  wire logic signed [15:0] x_bias,
   input  wire logic signed [15:0] y_bias,
   input  wire logic signed [16:0] z_bias,
   output logic                    q_valid,
   input  wire logic               q_pop,
   output ahgd_pkg::item_type      q_item
);
   import ahgd_pkg::*;
   item_type   mem_ff [2];
   logic       wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   it;
   logic       push;

   always_comb begin
      it.ax      = 17'(signed'(req_tdata[15:0])) - 17'(x_bias);
      it.ay      = 17'(signed'(req_tdata[31:16])) - 17'(y_bias);
      it.az      = 18'(signed'(req_tdata[47:32])) - 18'(z_bias);
      it.time_us = req_tdata[79:48];
      req_tready = cnt_ff != 2'd2;
      push       = req_tvalid && req_tready;
      q_valid    = cnt_ff != 2'd0;
      q_item     = mem_ff[rp_ff];
      wp_in      = push ? ~wp_ff : wp_ff;
      rp_in      = q_pop ? ~rp_ff : rp_ff;
      cnt_in     = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= it;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/ahgd_back.sv
// Back end: squares, iterative square roots, shared CORDIC, zone and hit logic.
// Depends on ahgd_pkg.
`default_nettype none
module ahgd_back #(
   parameter int CORDIC_STEPS = ahgd_pkg::CordicStepsDefault
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   output logic               q_pop,
   input  wire ahgd_pkg::item_type q_item,
   input  wire ahgd_pkg::ctl_type  ctl,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [55:0]        rsp_tdata
);
   import ahgd_pkg::*;
   localparam int NSTEPS = (CORDIC_STEPS < CordicStepsMax) ? CORDIC_STEPS : CordicStepsMax;

   typedef enum logic [3:0] {
      S_IDLE, S_SQ1, S_SQ2, S_SQRT_R, S_SQRT_M, S_PRE_P, S_CORD_P,
      S_PRE_R, S_CORD_R, S_DECIDE, S_OUT
   } state_type;

   state_type state_ff;
   item_type  it_ff;
   logic [35:0] sq_ff;        // ay^2 + az^2
   logic [35:0] sqm_ff;       // ax^2, added to sq_ff for the magnitude
   logic [35:0] v_ff, r_ff, bit_ff;
   logic [16:0] mag_ff;
   logic [18:0] rr_ff;
   logic signed [CorW-1:0] cx_ff, cy_ff;
   logic signed [AngW-1:0] cz_ff;
   logic [4:0]  i_ff;
   logic signed [10:0] pitch_ff;
   logic signed [11:0] roll_ff;
   logic signed [17:0] zh0_ff, zh1_ff;
   logic [16:0] mh0_ff, mh1_ff, peak_ff;
   logic [1:0]  hc_ff;
   logic        armed_ff, hit_ff;
   logic [31:0] arm_t_ff, last_t_ff;
   logic [2:0]  zone_ff;
   logic [10:0] inten_ff;

   logic signed [35:0] sq_a;
   logic signed [35:0] sq_x;
   logic signed [17:0] sq_op;
   logic [35:0] rb;
   logic [35:0] root, v_step;
   logic [16:0] mag_sat;
   logic signed [CorW-1:0] shx, shy;
   logic signed [CorW-1:0] px, py, pre_x, pre_y;
   logic signed [AngW-1:0] pre_z;
   logic signed [AngW+4:0] tz;
   logic signed [AngW+4:0] tsh;
   logic signed [12:0] tang;
   logic [2:0] zone;
   logic signed [18:0] dz2, dz1;
   logic signed [17:0] dm;
   logic signed [17:0] pdrop;
   logic [16:0] pk;
   logic [11:0] ip;
   logic        gap_ok;
   logic        arm_go, fire, drop;

   always_comb begin
      sq_op = (state_ff == S_SQ1) ? 18'(it_ff.ay) : it_ff.az;
      sq_a  = sq_op * sq_op;
      sq_x  = it_ff.ax * it_ff.ax;
      rb    = r_ff + bit_ff;
      root    = (v_ff >= rb) ? (r_ff >> 1) + bit_ff : r_ff >> 1;
      v_step  = (v_ff >= rb) ? v_ff - rb : v_ff;
      mag_sat = (root > 36'd131071) ? 17'h1ffff : 17'(root);
      // y, x operands; rotate into right half plane
      px = (state_ff == S_PRE_P) ? CorW'(signed'({1'b0, rr_ff})) <<< 8
                                 : CorW'(it_ff.az) <<< 8;
      py = (state_ff == S_PRE_P) ? -(CorW'(it_ff.ax) <<< 8)
                                 : CorW'(it_ff.ay) <<< 8;
      if (px < 0) begin
         if (py >= 0) begin
            pre_x = py; pre_y = -px; pre_z = AngW'(90 * 65536);
         end else begin
            pre_x = -py; pre_y = px; pre_z = AngW'(-90 * 65536);
         end
      end else begin
         pre_x = px; pre_y = py; pre_z = '0;
      end
      shx   = cx_ff >>> i_ff;
      shy   = cy_ff >>> i_ff;
      tz    = 37'(cz_ff) * 37'sd10 + 37'sd32768;
      tsh   = tz >>> 16;
      tang  = 13'(tsh);
      if (pitch_ff >= -11'sd900 && pitch_ff <= -11'sd100) zone = ZONE_SNARE;
      else if (roll_ff >= 12'sd300 && roll_ff <= 12'sd900) zone = ZONE_HIHAT;
      else if (roll_ff >= -12'sd900 && roll_ff <= -12'sd300) zone = ZONE_CRASH;
      else if (pitch_ff >= 11'sd400 && pitch_ff <= 11'sd900) zone = ZONE_TOM;
      else if (pitch_ff >= -11'sd150 && pitch_ff <= 11'sd300 &&
               roll_ff >= -12'sd200 && roll_ff <= 12'sd200) zone = ZONE_NEUTRAL;
      else zone = ctl.hand ? ZONE_SNARE : ZONE_HIHAT;
      dz2    = 19'(it_ff.az) - 19'(zh1_ff);
      dz1    = 19'(it_ff.az) - 19'(zh0_ff);
      dm     = 18'({1'b0, mag_ff}) - 18'({1'b0, mh1_ff});
      pk     = (mag_ff > peak_ff) ? mag_ff : peak_ff;
      pdrop  = 18'({1'b0, pk}) - 18'({1'b0, mag_ff});
      ip     = {1'b0, pk[16:5]} > 13'd1024 ? 12'd1024 :
               ({1'b0, pk[16:5]} < 13'd307 ? 12'd307 : 12'(pk[16:5]));
      gap_ok = (it_ff.time_us - last_t_ff) > ctl.min_gap;
      arm_go = gap_ok && !armed_ff && hc_ff == 2'd2 && mag_ff > 17'd14745 &&
               (dz2 > 19'sd14745 || dz2 < -19'sd14745 ||
                dm > 18'sd16384 || dm < -18'sd16384);
      fire   = gap_ok && armed_ff && hc_ff == 2'd2 &&
               (dz1 < -19'sd18022 || pdrop > 18'sd12288);
      drop   = gap_ok && armed_ff && hc_ff == 2'd2 &&
               (it_ff.time_us - arm_t_ff) > ctl.arm_win;
      q_pop  = (state_ff == S_IDLE) && q_valid;
      rsp_tvalid = state_ff == S_OUT;
      rsp_tdata  = {mag_ff, roll_ff, pitch_ff, armed_ff, inten_ff, zone_ff, hit_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         zh0_ff <= '0; zh1_ff <= '0; mh0_ff <= '0; mh1_ff <= '0;
         hc_ff <= '0; armed_ff <= 1'b0; arm_t_ff <= '0; peak_ff <= '0;
         last_t_ff <= '0; zone_ff <= ZONE_NEUTRAL;
      end else begin
         unique case (state_ff)
            S_IDLE: if (q_valid) begin
               it_ff <= q_item;
               state_ff <= S_SQ1;
            end
            S_SQ1: begin
               sq_ff <= 36'(sq_a);
               state_ff <= S_SQ2;
            end
            S_SQ2: begin
               sq_ff  <= sq_ff + 36'(sq_a);
               sqm_ff <= 36'(sq_x);
               v_ff   <= sq_ff + 36'(sq_a);
               r_ff   <= '0;
               bit_ff <= 36'h4_0000_0000;
               state_ff <= S_SQRT_R;
            end
            S_SQRT_R, S_SQRT_M: begin
               if (bit_ff[0]) begin
                  if (state_ff == S_SQRT_R) begin
                     rr_ff  <= 19'(root);
                     v_ff   <= sq_ff + sqm_ff;
                     r_ff   <= '0;
                     bit_ff <= 36'h4_0000_0000;
                     state_ff <= S_SQRT_M;
                  end else begin
                     mag_ff <= mag_sat;
                     state_ff <= S_PRE_P;
                  end
               end else begin
                  v_ff   <= v_step;
                  r_ff   <= root;
                  bit_ff <= bit_ff >> 2;
               end
            end
            S_PRE_P, S_PRE_R: begin
               cx_ff <= pre_x; cy_ff <= pre_y; cz_ff <= pre_z;
               i_ff  <= (px == 0 && py == 0) ? 5'(NSTEPS) : 5'd0;
               state_ff <= (state_ff == S_PRE_P) ? S_CORD_P : S_CORD_R;
            end
            S_CORD_P, S_CORD_R: begin
               if (i_ff != 5'(NSTEPS)) begin
                  if (cy_ff > 0) begin
                     cx_ff <= cx_ff + shy; cy_ff <= cy_ff - shx;
                     cz_ff <= cz_ff + atan_lut(i_ff);
                  end else begin
                     cx_ff <= cx_ff - shy; cy_ff <= cy_ff + shx;
                     cz_ff <= cz_ff - atan_lut(i_ff);
                  end
                  i_ff <= i_ff + 5'd1;
               end else if (state_ff == S_CORD_P) begin
                  pitch_ff <= tang > 13'sd900 ? 11'sd900 :
                              (tang < -13'sd900 ? -11'sd900 : 11'(tang));
                  state_ff <= S_PRE_R;
               end else begin
                  roll_ff <= tang > 13'sd1800 ? 12'sd1800 :
                             (tang < -13'sd1800 ? -12'sd1800 : 12'(tang));
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               hit_ff   <= fire;
               inten_ff <= fire ? 11'(ip) : 11'd0;
               if (arm_go || zone != ZONE_NEUTRAL) zone_ff <= zone;
               if (arm_go) begin
                  armed_ff <= 1'b1;
                  arm_t_ff <= it_ff.time_us;
                  peak_ff  <= mag_ff;
               end else if (gap_ok && armed_ff) begin
                  peak_ff <= pk;
                  if (fire || drop) armed_ff <= 1'b0;
                  if (fire) last_t_ff <= it_ff.time_us;
               end
               zh1_ff <= zh0_ff; zh0_ff <= it_ff.az;
               mh1_ff <= mh0_ff; mh0_ff <= mag_ff;
               if (hc_ff != 2'd2) hc_ff <= hc_ff + 2'd1;
               state_ff <= S_OUT;
            end
            S_OUT: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/accel_hit_gesture_detector_core.sv
// Top level of the accelerometer hit detector: config registers, front, back.
// Depends on ahgd_pkg, ahgd_front, ahgd_back.
//
//   channel | dir | fields
//   req     | in  | tdata: raw_x, raw_y, raw_z, time_us
//   rsp     | out | tdata: hit, drum, intensity, armed, pitch_out, roll_out, magnitude
//   csr     | in  | write enable, index, 20-bit data
//
// Each sample goes through two 18-step square roots and two passes through one
// shared CORDIC unit, and the back end takes no new sample until its response
// is taken; CORDIC_STEPS is capped at 24.
// Synchronous reset; the front queue takes two samples while the back stalls.
`default_nettype none
module accel_hit_gesture_detector_core #(
   parameter int CORDIC_STEPS = ahgd_pkg::CordicStepsDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [79:0]  req_tdata,   // raw_x, raw_y, raw_z, time_us
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [55:0]       rsp_tdata,   // hit, drum, intensity, armed, pitch, roll, mag
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [19:0]  csr_wdata
);
   import ahgd_pkg::*;
   logic signed [15:0] xb_ff, yb_ff;
   logic signed [16:0] zb_ff;
   logic        hand_ff;
   logic [19:0] gap_ff, win_ff;
   ctl_type     ctl;
   logic        q_valid, q_pop;
   item_type    q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         xb_ff <= '0; yb_ff <= '0; zb_ff <= '0; hand_ff <= 1'b0;
         gap_ff <= 20'd120000; win_ff <= 20'd60000;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_X_BIAS: xb_ff <= csr_wdata[15:0];
            CSR_Y_BIAS: yb_ff <= csr_wdata[15:0];
            CSR_Z_BIAS: zb_ff <= csr_wdata[16:0];
            CSR_HAND:   hand_ff <= csr_wdata[0];
            CSR_GAP:    gap_ff <= csr_wdata;
            CSR_WINDOW: win_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign ctl = '{min_gap: {12'd0, gap_ff}, arm_win: {12'd0, win_ff}, hand: hand_ff};

   ahgd_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .x_bias(xb_ff), .y_bias(yb_ff), .z_bias(zb_ff),
      .q_valid, .q_pop, .q_item
   );

   ahgd_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_item, .ctl,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );
endmodule
`default_nettype wire

FILE: dv/gesture_checker.sv
// Checker for the accelerometer hit detector: watches the req, rsp and csr ports,
// predicts each response beat from its own copy of the state, and compares field by field.
// Depends on ahgd_pkg.
module gesture_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [79:0]  req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [55:0]  rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [19:0]  csr_wdata,
   output int                fail_count,
   output int                pending,
   output int                checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import ahgd_pkg::*;

   localparam int Steps = CordicStepsDefault;
   localparam longint MagMax = 131071;

   typedef struct packed {
      logic [16:0] mag;
      logic [11:0] roll;
      logic [10:0] pitch;
      logic        armed;
      logic [10:0] intensity;
      logic [2:0]  drum;
      logic        hit;
   } sample_out_t;

   const longint atan_deg[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
      58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

   sample_out_t predicted_outputs[$];

   // shadow registers
   longint      xb, yb, zb;
   logic        hand;
   logic [19:0] min_gap, arm_win;
   // detector state
   longint      z_prev, z_prev2;
   longint      m_prev, m_prev2;
   int          hist_n;
   logic        armed_st;
   logic [31:0] arm_t0, last_hit_t;
   longint      peak;
   logic [2:0]  zone_q;

   function automatic longint unsigned isqrt64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint angle10(longint y, longint x, longint lim);
      longint z, t, nx;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * 256;
      y = y * 256;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 90 * 65536;
         end else begin
            t = x; x = -y; y = t; z = -90 * 65536;
         end
      end
      for (int i = 0; i < Steps && i < 24; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + atan_deg[i];
         end else begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - atan_deg[i];
         end
         x = nx;
      end
      t = (z * 10 + 32768) >>> 16;
      if (t > lim) t = lim;
      if (t < -lim) t = -lim;
      return t;
   endfunction

   function automatic logic [2:0] zone_of(longint p, longint r);
      if (p >= -900 && p <= -100) return ZONE_SNARE;
      if (r >= 300 && r <= 900) return ZONE_HIHAT;
      if (r >= -900 && r <= -300) return ZONE_CRASH;
      if (p >= 400 && p <= 900) return ZONE_TOM;
      if (p >= -150 && p <= 300 && r >= -200 && r <= 200) return ZONE_NEUTRAL;
      return hand ? ZONE_SNARE : ZONE_HIHAT;
   endfunction

   function automatic sample_out_t predict_sample(logic [79:0] d);
      sample_out_t o;
      longint ax, ay, az, pitch, roll, dz, dm, mag, inten;
      longint unsigned m64, rr;
      logic [31:0] t;
      logic [2:0]  zn;
      logic        hit;
      ax = longint'($signed(d[15:0])) - xb;
      ay = longint'($signed(d[31:16])) - yb;
      az = longint'($signed(d[47:32])) - zb;
      t  = d[79:48];
      hit = 1'b0;
      inten = 0;
      m64 = isqrt64(ax * ax + ay * ay + az * az);
      mag = (m64 > MagMax) ? MagMax : longint'(m64);
      rr = isqrt64(ay * ay + az * az);
      pitch = angle10(-ax, longint'(rr), 900);
      roll  = angle10(ay, az, 1800);
      zn = zone_of(pitch, roll);
      if (zn != ZONE_NEUTRAL) zone_q = zn;
      if (32'(t - last_hit_t) > {12'd0, min_gap}) begin
         if (!armed_st) begin
            if (hist_n >= 2) begin
               dz = az - z_prev2;
               dm = mag - m_prev2;
               if ((dz > 14745 || dz < -14745 || dm > 16384 || dm < -16384)
                   && mag > 14745) begin
                  armed_st = 1'b1;
                  arm_t0 = t;
                  peak = mag;
                  zone_q = zn;
               end
            end
         end else begin
            if (mag > peak) peak = mag;
            if (hist_n >= 2) begin
               dz = az - z_prev;
               if (dz < -18022 || peak - mag > 12288) begin
                  inten = peak / 32;
                  if (inten > 1024) inten = 1024;
                  if (inten < 307) inten = 307;
                  armed_st = 1'b0;
                  last_hit_t = t;
                  hit = 1'b1;
               end else if (32'(t - arm_t0) > {12'd0, arm_win}) begin
                  armed_st = 1'b0;
               end
            end
         end
      end
      z_prev2 = z_prev;
      z_prev  = az;
      m_prev2 = m_prev;
      m_prev  = mag;
      if (hist_n < 2) hist_n++;
      o.hit = hit;
      o.drum = zone_q;
      o.intensity = inten[10:0];
      o.armed = armed_st;
      o.pitch = pitch[10:0];
      o.roll = roll[11:0];
      o.mag = mag[16:0];
      return o;
   endfunction

   task automatic cmp_field(string n, longint e, longint a);
      if (e != a) begin
         $display("%0t ns: mismatch in %s, expected %0d, got %0d", $time, n, e, a);
         fail_count++;
      end
   endtask

   assign pending = predicted_outputs.size();

   initial begin
      fail_count = 0;
      checked = 0;
   end

   always @(posedge clock) begin
      sample_out_t e, a;
      if (reset) begin
         xb = 0; yb = 0; zb = 0;
         hand = 1'b0; min_gap = 20'd120000; arm_win = 20'd60000;
         z_prev = 0; z_prev2 = 0; m_prev = 0; m_prev2 = 0; hist_n = 0;
         armed_st = 1'b0; arm_t0 = '0; last_hit_t = '0; peak = 0;
         zone_q = ZONE_NEUTRAL;
         predicted_outputs.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_X_BIAS: xb = longint'($signed(csr_wdata[15:0]));
               CSR_Y_BIAS: yb = longint'($signed(csr_wdata[15:0]));
               CSR_Z_BIAS: zb = longint'($signed(csr_wdata[16:0]));
               CSR_HAND:   hand = csr_wdata[0];
               CSR_GAP:    min_gap = csr_wdata;
               CSR_WINDOW: arm_win = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            a = rsp_tdata[55:0];
            if (predicted_outputs.size() == 0) begin
               $display("%0t ns: unexpected response beat, expected none, got %h", $time, a);
               fail_count++;
            end else begin
               e = predicted_outputs.pop_front();
               checked++;
               cmp_field("hit", e.hit, a.hit);
               cmp_field("drum", e.drum, a.drum);
               cmp_field("intensity", e.intensity, a.intensity);
               cmp_field("armed", e.armed, a.armed);
               cmp_field("pitch", $signed(e.pitch), $signed(a.pitch));
               cmp_field("roll", $signed(e.roll), $signed(a.roll));
               cmp_field("magnitude", e.mag, a.mag);
            end
         end
         if (req_tvalid && req_tready) predicted_outputs.push_back(predict_sample(req_tdata));
      end
   end
endmodule

FILE: dv/testbench.sv
// Top of the hit detector testbench: clock, reset, register setup and sample stimulus.
// Depends on ahgd_pkg, accel_hit_gesture_detector_core and gesture_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ahgd_pkg::*;

   logic         clock, reset;
   logic         req_tvalid, req_tready;
   logic [79:0]  req_tdata;
   logic         rsp_tvalid, rsp_tready;
   logic [55:0]  rsp_tdata;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [19:0]  csr_wdata;
   int           fail_count, pending, checked;
   int           tx_idle, rx_idle, n_sent, n_hits;
   logic [31:0]  now_us;
   int           gxb, gyb, gzb;

   accel_hit_gesture_detector_core u_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_index, .csr_wdata
   );

   gesture_checker u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_index, .csr_wdata,
      .fail_count, .pending, .checked
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= rx_idle);
   end

   always @(posedge clock)
      if (rsp_tvalid && rsp_tready && rsp_tdata[0]) n_hits++;

   function automatic logic [15:0] sat16(int v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                              logic [31:0] t);
      bit got;
      if ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {t, z, y, x};
      do begin
         @(negedge clock);
         got = req_tready;
         @(posedge clock);
      end while (!got);
      n_sent++;
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v[19:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic setup(int xb, int yb, int zb, bit hand, int gap, int win);
      drain();
      csr_write(CSR_X_BIAS, xb);
      csr_write(CSR_Y_BIAS, yb);
      csr_write(CSR_Z_BIAS, zb);
      csr_write(CSR_HAND, hand);
      csr_write(CSR_GAP, gap);
      csr_write(CSR_WINDOW, win);
      gxb = xb; gyb = yb; gzb = zb;
   endtask

   // send one sample given bias-free acceleration, advance the timestamp
   task automatic send_accel(int ax, int ay, int az);
      if ($urandom_range(29) == 0) now_us = now_us + $urandom_range(200000);
      else now_us = now_us + $urandom_range(4000, 500);
      send_sample(sat16(ax + gxb), sat16(ay + gyb), sat16(az + gzb), now_us);
   endtask

   // rest, swing, optional peak, then stop: a well-formed drum stroke
   task automatic stroke();
      int bx, by, bz, sw, n;
      bx = $urandom_range(16000) - 8000;
      by = $urandom_range(16000) - 8000;
      bz = $urandom_range(12000) - 4000;
      n = $urandom_range(4, 1);
      repeat (n)
         send_accel(bx + $urandom_range(600) - 300, by + $urandom_range(600) - 300,
                    bz + $urandom_range(600) - 300);
      sw = $urandom_range(30000, 12000);
      send_accel(bx, by, bz + sw);
      repeat ($urandom_range(2))
         send_accel(bx + $urandom_range(4000) - 2000, by, bz + sw + $urandom_range(8000));
      if ($urandom_range(1)) send_accel(bx, by, bz + sw - $urandom_range(40000, 19000));
      else send_accel(bx / 4, by / 4, (bz + sw) / 4);
   endtask

   task automatic noise();
      logic [31:0] a, b;
      a = $urandom;
      b = $urandom;
      if ($urandom_range(1)) now_us = $urandom;
      send_sample(a[15:0], a[31:16], b[15:0], now_us);
   endtask

   initial begin
      int p;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      tx_idle = 22;
      rx_idle = 72;
      n_sent = 0;
      n_hits = 0;
      now_us = '0;
      gxb = 0; gyb = 0; gzb = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, zero vector, extremes, timestamp wrap
      send_sample(16'h0000, 16'h0000, 16'h0000, 32'd0);
      send_sample(16'h7fff, 16'h7fff, 16'h7fff, 32'd1);
      send_sample(16'h8000, 16'h8000, 16'h8000, 32'hffffffff);
      send_sample(16'h8000, 16'h0000, 16'h7fff, 32'd200000);
      send_sample(16'h7fff, 16'h0000, 16'h8000, 32'd200001);
      send_sample(16'h0000, 16'h7fff, 16'h8000, 32'd400000);
      send_sample(16'h0000, 16'h8000, 16'h0000, 32'd600000);
      setup(32767, -32768, 24575, 1'b1, 0, 0);
      send_sample(16'h7fff, 16'h8000, 16'h5fff, 32'd10);
      send_sample(16'h8000, 16'h7fff, 16'h8000, 32'd20);
      send_sample(16'h8000, 16'h7fff, 16'h8000, 32'd30);
      send_sample(16'h7fff, 16'h8000, 16'h7fff, 32'd40);
      send_sample(16'h7fff, 16'h8000, 16'h8000, 32'd50);
      setup(-32768, 32767, -40960, 1'b0, 1048575, 1048575);
      send_sample(16'h8000, 16'h7fff, 16'h8000, 32'hfffffff0);
      send_sample(16'h7fff, 16'h8000, 16'h7fff, 32'h00000010);
      send_sample(16'h0000, 16'h0000, 16'h7fff, 32'h00200000);
      setup(0, 0, 0, 1'b0, 0, 60000);
      gzb = 0;
      send_accel(0, 0, 8192);
      send_accel(0, 0, 8192);
      send_accel(0, 0, 30000);
      send_accel(0, 0, 32767);
      send_accel(0, 0, 0);
      send_accel(-4000, 6000, 8192);
      send_accel(-4000, 6000, 30000);
      send_accel(-4000, 6000, 29000);
      send_accel(-1000, 1500, 7000);

      for (p = 0; p < 3; p++) begin
         if (p == 0) begin tx_idle = 22; rx_idle = 72; end
         else if (p == 1) begin tx_idle = 72; rx_idle = 22; end
         else begin tx_idle = 0; rx_idle = 0; end
         setup($urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
               $urandom_range(4000) - 2000 + ((p == 1) ? 8192 : 0), p[0],
               (p == 2) ? 120000 : $urandom_range(20000), $urandom_range(100000, 2000));
         if (p == 1) now_us = 32'hfff00000;
         for (int k = n_sent + 250; n_sent < k;) begin
            if ($urandom_range(4) == 0) noise();
            else stroke();
            if (n_sent >= k - 125 && n_sent < k - 118) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
         end
      end

      drain();
      $display("Sent %0d samples over three register settings and stall mixes;",
               n_sent);
      $display("checked %0d responses, %0d of them hits.", checked, n_hits);
      if (fail_count == 0 && pending == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
